### hw/rtl/ritoa_pkg.sv
// ----------------------------------------------------------------------------
// ritoa_pkg
// Shared types, constants and the digit-to-character map for the radix
// integer-to-ASCII converter.
// ----------------------------------------------------------------------------
package ritoa_pkg;

	localparam int RADIX_W     = 6;
	localparam int CHAR_W      = 7;
	localparam int STORE_DEPTH = 32;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int COUNT_W     = IDX_W + 1;
	localparam int REM_W       = RADIX_W;

	localparam logic [RADIX_W-1:0] RADIX_MIN    = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX    = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_RESET  = RADIX_W'(10);
	localparam logic [REM_W-1:0]   DECIMAL_BASE = REM_W'(10);
	localparam logic [CHAR_W-1:0]  CHAR_ZERO    = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0]  CHAR_A       = CHAR_W'(8'h61);

	typedef struct packed {
		logic start;
		logic bad;
		logic div_en;
		logic rd_en;
		logic out_load;
	} ritoa_cmd_t;

	typedef struct packed {
		logic radix_ok;
		logic bit_last;
		logic conv_done;
		logic k_zero;
		logic out_free;
	} ritoa_sts_t;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [REM_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DECIMAL_BASE) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - DECIMAL_BASE);
		end
		return c;
	endfunction

endpackage

### hw/rtl/ritoa_dp.sv
// ----------------------------------------------------------------------------
// ritoa_dp
// Datapath: radix register, bit-serial restoring divider, digit memory,
// registered memory read and output register.
// ----------------------------------------------------------------------------
module ritoa_dp
	import ritoa_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ritoa_cmd_t             cmd,
	output ritoa_sts_t             sts,
	input  logic                   radix_we,
	input  logic [RADIX_W-1:0]     radix_wdata,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [CHAR_W-1:0]      digit_char,
	output logic                   last
);

	localparam int BIT_W = $clog2(VALUE_WIDTH);
	localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_WIDTH - 1);

	logic [RADIX_W-1:0]     radix_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [REM_W-1:0]       rem_q;
	logic [BIT_W-1:0]       bitcnt_q;
	logic [COUNT_W-1:0]     count_q;
	logic [IDX_W-1:0]       k_q;
	logic                   zero_q;
	logic [REM_W-1:0]       mem_q [STORE_DEPTH];
	logic [REM_W-1:0]       rdata_q;
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;

	logic [REM_W:0]         rem_sh;
	logic                   ge;
	logic [REM_W-1:0]       rem_nx;
	logic [VALUE_WIDTH-1:0] quo_nx;

	always_comb begin
		rem_sh = {rem_q, quo_q[VALUE_WIDTH-1]};
		ge     = rem_sh >= {1'b0, radix_q};
		rem_nx = ge ? REM_W'(rem_sh - {1'b0, radix_q}) : rem_sh[REM_W-1:0];
		quo_nx = {quo_q[VALUE_WIDTH-2:0], ge};
	end

	assign sts.radix_ok  = (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX);
	assign sts.bit_last  = bitcnt_q == BIT_LAST;
	assign sts.conv_done = (quo_nx == '0) || (count_q == COUNT_W'(STORE_DEPTH - 1));
	assign sts.k_zero    = k_q == '0;
	assign sts.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_we) begin
			radix_q <= radix_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q    <= '0;
			rem_q    <= '0;
			bitcnt_q <= '0;
			count_q  <= '0;
			k_q      <= '0;
			zero_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				quo_q    <= value;
				rem_q    <= '0;
				bitcnt_q <= '0;
				count_q  <= '0;
				zero_q   <= 1'b0;
			end
			if (cmd.bad) begin
				zero_q <= 1'b1;
				k_q    <= '0;
			end
			if (cmd.div_en) begin
				quo_q <= quo_nx;
				if (sts.bit_last) begin
					rem_q    <= '0;
					bitcnt_q <= '0;
					count_q  <= count_q + COUNT_W'(1);
					k_q      <= count_q[IDX_W-1:0];
				end else begin
					rem_q    <= rem_nx;
					bitcnt_q <= bitcnt_q + BIT_W'(1);
				end
			end
			if (cmd.out_load) begin
				k_q <= k_q - IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_en && sts.bit_last) begin
			mem_q[count_q[IDX_W-1:0]] <= rem_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem_q[k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			char_q <= zero_q ? CHAR_ZERO : digit_to_char(rdata_q);
			last_q <= k_q == '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = char_q;
	assign last       = last_q;

endmodule

### hw/rtl/ritoa_ctrl.sv
// ----------------------------------------------------------------------------
// ritoa_ctrl
// Controller: sequences request intake, digit division, digit readout and
// character emission.
// ----------------------------------------------------------------------------
module ritoa_ctrl
	import ritoa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  ritoa_sts_t sts,
	output ritoa_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_READ = 4'b0100,
		ST_LOAD = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = sts.radix_ok;
					cmd.bad   = !sts.radix_ok;
					state_nx  = sts.radix_ok ? ST_DIV : ST_LOAD;
				end
			end
			ST_DIV: begin
				cmd.div_en = 1'b1;
				if (sts.bit_last && sts.conv_done) begin
					state_nx = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_nx  = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = sts.k_zero ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

### hw/rtl/radix_integer_to_ascii.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii
// Converts an unsigned integer to ASCII digits in a configured radix from
// 2 to 36, most significant digit first, one character per result.
//
//   channel   signals                            direction
//   input     in_valid, in_stall, value          request in
//   output    out_valid, out_stall, digit_char,  result out
//             last
//   config    radix_we, radix_wdata              register write
//
// Each digit comes from a bit-serial division over all VALUE_WIDTH bits of the
// quotient, then each character passes a memory read and an output load.
// A radix outside 2 to 36 gives one '0'.
// Reset clears the controller, counters and output valid; radix returns to 10.
// A stalled output holds the controller in its load state with the next digit
// waiting in the read register.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii
	import ritoa_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   radix_we,
	input  logic [RADIX_W-1:0]     radix_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CHAR_W-1:0]      digit_char,
	output logic                   last
);

	ritoa_cmd_t cmd;
	ritoa_sts_t sts;

	ritoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ritoa_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.value       (value),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.digit_char  (digit_char),
		.last        (last)
	);

endmodule

### verif/radix_integer_to_ascii_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_tb
// Drives unsigned values through the radix converter and checks every
// output character, and its last flag, against expected text or a local
// model of the conversion. A directed table covers the radix limits, the
// out-of-range radixes and the extreme values. Random phases then follow,
// each with its own radix, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii_tb;
	import ritoa_pkg::*;

	localparam int VW         = 32;
	localparam int NUM_ROWS   = 21;
	localparam int NUM_PHASES = 10;
	localparam int PHASE_LEN  = 40;
	localparam int SETTLE     = 1100;
	localparam int MAX_SHOWN  = 10;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_A    = 7'h61;
	localparam logic [RADIX_W-1:0] TEN       = 6'd10;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              fin;
	} char_t;

	typedef struct {
		logic [RADIX_W-1:0] radix;
		logic [VW-1:0]      val;
		string              text;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               radix_we;
	logic [RADIX_W-1:0] radix_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [VW-1:0]      value;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [CHAR_W-1:0]  digit_char;
	logic               last;

	char_t              pending_chars[$];
	logic [RADIX_W-1:0] cur_radix = RADIX_RESET;
	int                 mismatches = 0;
	bit                 in_quiet = 1'b0;
	bit                 out_quiet = 1'b0;
	int                 stall_left = 0;
	row_t               dir_rows [NUM_ROWS];

	radix_integer_to_ascii #(.VALUE_WIDTH(VW)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.radix_we   (radix_we),
		.radix_wdata(radix_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_char (digit_char),
		.last       (last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int idle_len(input bit quiet);
		int p;
		p = $urandom_range(0, 99);
		if (quiet || p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CHAR_W-1:0] ascii_digit(input logic [RADIX_W-1:0] d);
		if (d < TEN) return ASCII_ZERO + CHAR_W'(d);
		return ASCII_A + CHAR_W'(d - TEN);
	endfunction

	function automatic void predict_chars(input logic [VW-1:0] v,
			input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] digits[$];
		logic [VW-1:0]      q;
		if (r < RADIX_MIN || r > RADIX_MAX) begin
			pending_chars.push_back('{ch: ASCII_ZERO, fin: 1'b1});
			return;
		end
		q = v;
		do begin
			digits.push_front(RADIX_W'(q % VW'(r)));
			q = q / VW'(r);
		end while (q != 0);
		foreach (digits[i])
			pending_chars.push_back('{ch: ascii_digit(digits[i]), fin: i == digits.size() - 1});
	endfunction

	function automatic void load_text(input string s);
		for (int i = 0; i < s.len(); i++)
			pending_chars.push_back('{ch: CHAR_W'(s[i]), fin: i == s.len() - 1});
	endfunction

	task automatic push_request(input logic [VW-1:0] v, input string text);
		int gap;
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall);
		if (text.len() == 0) predict_chars(v, cur_radix);
		else load_text(text);
		gap = idle_len(in_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_chars.size() != 0);
	endtask

	task automatic set_radix(input logic [RADIX_W-1:0] r);
		wait_idle();
		radix_we    <= 1'b1;
		radix_wdata <= r;
		cur_radix = r;
		@(posedge clk);
		radix_we <= 1'b0;
	endtask

	function automatic logic [VW-1:0] pick_value(input logic [RADIX_W-1:0] r);
		logic [63:0] p;
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $urandom_range(0, 99);
			2: begin
				p = 64'd1;
				repeat ($urandom_range(1, 32))
					if (p * 64'(r) < 64'h1_0000_0000) p = p * 64'(r);
				return VW'(p - 64'($urandom_range(0, 1)));
			end
			3: return $urandom() >> $urandom_range(0, 31);
			default: return $urandom_range(0, 1) ? {VW{1'b1}} : VW'(r);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input char_t want, input char_t got);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%0t: %s: expected char %02h last %0b, got char %02h last %0b",
				$realtime, what, want.ch, want.fin, got.ch, got.fin);
	endtask

	always @(posedge clk) begin
		char_t want;
		char_t got;
		if (out_valid && !out_stall) begin
			got = '{ch: digit_char, fin: last};
			if (pending_chars.size() == 0) begin
				report_mismatch("unexpected character", '0, got);
			end else begin
				want = pending_chars.pop_front();
				if (got !== want) report_mismatch("character mismatch", want, got);
			end
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 99) < 30) stall_left = idle_len(out_quiet);
		end
		if ($urandom_range(0, 399) == 0) out_quiet = !out_quiet;
	end

	initial begin
		#50_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [RADIX_W-1:0] r;
		arst_n      = 1'b0;
		radix_we    = 1'b0;
		radix_wdata = '0;
		in_valid    = 1'b0;
		value       = '0;
		dir_rows = '{
			'{6'd10, 32'd0,          "0"},
			'{6'd10, 32'd9,          "9"},
			'{6'd10, 32'd10,         "10"},
			'{6'd10, 32'hFFFF_FFFF,  "4294967295"},
			'{6'd10, 32'd1234567890, ""},
			'{6'd2,  32'd0,          "0"},
			'{6'd2,  32'd1,          "1"},
			'{6'd2,  32'hFFFF_FFFF,  "11111111111111111111111111111111"},
			'{6'd2,  32'h8000_0000,  ""},
			'{6'd2,  32'h5555_5555,  ""},
			'{6'd36, 32'd35,         "z"},
			'{6'd36, 32'd36,         "10"},
			'{6'd36, 32'hFFFF_FFFF,  "1z141z3"},
			'{6'd36, 32'hDEAD_BEEF,  ""},
			'{6'd16, 32'hFFFF_FFFF,  "ffffffff"},
			'{6'd16, 32'h0123_ABCD,  ""},
			'{6'd0,  32'd12345,      "0"},
			'{6'd1,  32'hFFFF_FFFF,  "0"},
			'{6'd37, 32'd100,        "0"},
			'{6'd63, 32'hFFFF_FFFF,  "0"},
			'{6'd8,  32'hFFFF_FFFF,  "37777777777"}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].radix != cur_radix) set_radix(dir_rows[i].radix);
			push_request(dir_rows[i].val, dir_rows[i].text);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			r = ($urandom_range(0, 4) == 0) ? RADIX_W'($urandom_range(0, 63))
				: RADIX_W'($urandom_range(2, 36));
			set_radix(r);
			for (int n = 0; n < PHASE_LEN; n++) begin
				if ($urandom_range(0, 29) == 0) in_quiet = !in_quiet;
				push_request(pick_value(r), "");
			end
		end

		wait_idle();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_chars.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
